FILE: hdl/u8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
package u8sd_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned ResIdxW    = $clog2(MaxResults);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [20:0] MinTwoByte   = 21'h00_0080;
  localparam logic [20:0] MinThreeByte = 21'h00_0800;
  localparam logic [20:0] MinFourByte  = 21'h01_0000;
  localparam logic [20:0] SurrogateLo  = 21'h00_D800;
  localparam logic [20:0] SurrogateHi  = 21'h00_DFFF;
  localparam logic [20:0] MaxScalar    = 21'h10_FFFF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_req_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  seq_length;
    logic        run_last;
  } out_req_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  seq_length;
  } item_t;

  // All results caused by one input byte.
  typedef struct packed {
    logic [ResIdxW-1:0]         last_idx;
    item_t [MaxResults-1:0]     item;
  } job_t;

endpackage

FILE: hdl/u8sd_front.sv
// Front end: accepts bytes, tracks the pending sequence and builds result jobs.
module u8sd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  u8sd_pkg::in_req_t in_req_i,
  input  logic              full_i,
  output logic              push_o,
  output u8sd_pkg::job_t    job_o
);
  import u8sd_pkg::*;

  logic [7:0]  lead_q, lead_d;
  logic [20:0] part_q, part_d;
  logic [1:0]  exp_q, exp_d;
  logic [1:0]  held_q, held_d;
  logic [7:0]  hold_q [3];

  logic        accept;
  logic [7:0]  b;
  logic        eob;
  logic        pending;
  logic        is_cont;
  logic [1:0]  lead_need;
  logic [20:0] lead_val;
  logic [7:0]  hb [3];
  logic [20:0] pv;
  logic [1:0]  held_inc;
  logic        complete;
  logic        val_ok;
  logic        fresh;
  logic        success;
  logic        do_flush;
  logic [1:0]  flush_held;
  logic        add_byte;
  logic [2:0]  n_res;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;
  assign b          = in_req_i.in_byte;
  assign eob        = in_req_i.end_of_buffer;
  assign pending    = (exp_q != 2'd0);
  assign is_cont    = (b[7:6] == 2'b10);
  assign pv         = {part_q[14:0], b[5:0]};
  assign held_inc   = held_q + 2'd1;
  assign complete   = (held_inc == exp_q);

  always_comb begin
    lead_need = 2'd0;
    lead_val  = '0;
    if (b[7:5] == 3'b110) begin
      lead_need = 2'd1;
      lead_val  = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      lead_need = 2'd2;
      lead_val  = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      lead_need = 2'd3;
      lead_val  = {18'd0, b[2:0]};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hb[i] = (is_cont && held_q == 2'(i)) ? b : hold_q[i];
    end
  end

  always_comb begin
    val_ok = 1'b1;
    if (exp_q == 2'd1 && pv < MinTwoByte) val_ok = 1'b0;
    if (exp_q == 2'd2 && pv < MinThreeByte) val_ok = 1'b0;
    if (exp_q == 2'd3 && pv < MinFourByte) val_ok = 1'b0;
    if (pv >= SurrogateLo && pv <= SurrogateHi) val_ok = 1'b0;
    if (pv > MaxScalar) val_ok = 1'b0;
  end

  always_comb begin
    lead_d     = lead_q;
    part_d     = part_q;
    exp_d      = exp_q;
    held_d     = held_q;
    success    = 1'b0;
    do_flush   = 1'b0;
    flush_held = held_q;
    add_byte   = 1'b0;
    fresh      = 1'b0;

    if (!pending) begin
      fresh = 1'b1;
    end else if (is_cont) begin
      part_d = pv;
      held_d = held_inc;
      if (complete || eob) begin
        lead_d = '0;
        part_d = '0;
        exp_d  = '0;
        held_d = '0;
        if (complete && val_ok) begin
          success = 1'b1;
        end else begin
          do_flush   = 1'b1;
          flush_held = held_inc;
        end
      end
    end else begin
      do_flush   = 1'b1;
      flush_held = held_q;
      lead_d     = '0;
      part_d     = '0;
      exp_d      = '0;
      held_d     = '0;
      fresh      = 1'b1;
    end

    if (fresh) begin
      if (lead_need != 2'd0 && !eob) begin
        lead_d = b;
        part_d = lead_val;
        exp_d  = lead_need;
        held_d = '0;
      end else begin
        add_byte = 1'b1;
      end
    end
  end

  always_comb begin
    n_res = {2'd0, add_byte};
    if (success) begin
      n_res = 3'd1;
    end else if (do_flush) begin
      n_res = 3'd1 + {1'b0, flush_held} + {2'd0, add_byte};
    end
  end

  always_comb begin
    job_o.last_idx = ResIdxW'(n_res - 3'd1);
    if (success) begin
      job_o.item[0] = '{code_point: pv, seq_length: {1'b0, exp_q} + 3'd1};
    end else if (do_flush) begin
      job_o.item[0] = '{code_point: {13'd0, lead_q}, seq_length: 3'd1};
    end else begin
      job_o.item[0] = '{code_point: {13'd0, b}, seq_length: 3'd1};
    end
    for (int i = 1; i < MaxResults; i++) begin
      if (do_flush && 2'(i) <= flush_held) begin
        job_o.item[i] = '{code_point: {13'd0, hb[i-1]}, seq_length: 3'd1};
      end else begin
        job_o.item[i] = '{code_point: {13'd0, b}, seq_length: 3'd1};
      end
    end
  end

  assign push_o = accept & (n_res != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= '0;
      part_q <= '0;
      exp_q  <= '0;
      held_q <= '0;
    end else if (accept) begin
      lead_q <= lead_d;
      part_q <= part_d;
      exp_q  <= exp_d;
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pending && is_cont) begin
      hold_q[held_q] <= b;
    end
  end

  a_held_below_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_q != 2'd0 |-> held_q < exp_q)
    else $error("held count not below expected count");

  a_lead_is_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_q != 2'd0 |-> lead_q[7:6] == 2'b11)
    else $error("pending sequence without a lead byte");

endmodule

FILE: hdl/u8sd_queue.sv
// Short job queue between the decode front end and the emitting back end.
module u8sd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  u8sd_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output u8sd_pkg::job_t pop_job_o
);
  import u8sd_pkg::*;

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o    = (cnt_q == QCntW'(QueueDepth));
  assign empty_o   = (cnt_q == '0);
  assign pop_job_o = mem_q[rd_q];
  assign do_push   = push_i & ~full_o;
  assign do_pop    = pop_i & ~empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QueueDepth))
    else $error("queue count beyond depth");

endmodule

FILE: hdl/u8sd_back.sv
// Back end: walks each job and hands out its results one request at a time.
module u8sd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  u8sd_pkg::job_t     job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output u8sd_pkg::out_req_t out_req_o
);
  import u8sd_pkg::*;

  job_t               cur_q;
  logic               cur_valid_q;
  logic [ResIdxW-1:0] idx_q;
  logic               out_take;
  logic               at_last;
  item_t              cur_item;

  assign at_last  = (idx_q == cur_q.last_idx);
  assign out_take = cur_valid_q & ~out_stall_i;
  assign pop_o    = ~empty_i & (~cur_valid_q | (out_take & at_last));
  assign cur_item = cur_q.item[idx_q];

  assign out_valid_o          = cur_valid_q;
  assign out_req_o.code_point = cur_item.code_point;
  assign out_req_o.seq_length = cur_item.seq_length;
  assign out_req_o.run_last   = at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (pop_o) begin
      cur_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (out_take) begin
      if (at_last) begin
        cur_valid_q <= 1'b0;
        idx_q       <= '0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= job_i;
    end
  end

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> idx_q <= cur_q.last_idx)
    else $error("result index past end of job");

endmodule

FILE: hdl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: front end, job queue and back end.
// Throughput is one byte per cycle while the job queue is not full. The back end
// hands out a byte's n results one result per cycle while the output is not
// stalled; a byte that only opens or extends a sequence pushes no job. A
// two-entry job queue between the decode front end and the emitting back end
// lets input run ahead while a multi-result flush drains; when it is full the
// input stalls. A byte's job is queued, then loaded into the back end's job register.
module utf8_stream_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  u8sd_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output u8sd_pkg::out_req_t out_req_o
);
  import u8sd_pkg::*;

  logic push, full, pop, empty;
  job_t push_job, pop_job;

  u8sd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  u8sd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_job_o  (pop_job)
  );

  u8sd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

FILE: dv/utf8_stream_decoder_test.sv
// Self-checking testbench for the UTF-8 stream decoder: byte stimulus, code point scoreboard.
`timescale 1ns / 100ps

class utf8_scoreboard;
  logic [7:0]  lead;
  logic [20:0] partial;
  logic [1:0]  need;
  logic [1:0]  held;
  logic [7:0]  conts [3];
  u8sd_pkg::out_req_t code_points_due [$];
  u8sd_pkg::out_req_t byte_results [$];
  int errors;

  function new();
    clear();
    errors = 0;
  endfunction

  function void clear();
    need    = '0;
    held    = '0;
    partial = '0;
    lead    = '0;
  endfunction

  function void emit(logic [20:0] cp, logic [2:0] len);
    u8sd_pkg::out_req_t r;
    r.code_point = cp;
    r.seq_length = len;
    r.run_last   = 1'b0;
    byte_results.push_back(r);
  endfunction

  // lead first, then every continuation held so far, one byte per result
  function void flush();
    emit({13'd0, lead}, 3'd1);
    for (int i = 0; i < int'(held); i++) emit({13'd0, conts[i]}, 3'd1);
    clear();
  endfunction

  function void take_fresh(logic [7:0] b, logic eob);
    casez (b)
      8'b0???????: begin
        emit({13'd0, b}, 3'd1);
        return;
      end
      8'b110?????: begin
        need    = 2'd1;
        partial = {16'd0, b[4:0]};
      end
      8'b1110????: begin
        need    = 2'd2;
        partial = {17'd0, b[3:0]};
      end
      8'b11110???: begin
        need    = 2'd3;
        partial = {18'd0, b[2:0]};
      end
      default: begin
        emit({13'd0, b}, 3'd1);
        return;
      end
    endcase
    lead = b;
    held = '0;
    if (eob) flush();
  endfunction

  function void note_byte(u8sd_pkg::in_req_t req);
    logic [7:0]         b;
    logic               eob;
    logic               ok;
    u8sd_pkg::out_req_t r;
    b   = req.in_byte;
    eob = req.end_of_buffer;
    byte_results.delete();
    if (need == 2'd0) begin
      take_fresh(b, eob);
    end else if (b[7:6] == 2'b10) begin
      conts[held] = b;
      partial     = {partial[14:0], b[5:0]};
      held        = held + 2'd1;
      if (held == need) begin
        ok = 1'b1;
        case (need)
          2'd1:    if (partial < u8sd_pkg::MinTwoByte) ok = 1'b0;
          2'd2:    if (partial < u8sd_pkg::MinThreeByte) ok = 1'b0;
          default: if (partial < u8sd_pkg::MinFourByte) ok = 1'b0;
        endcase
        if (partial >= u8sd_pkg::SurrogateLo && partial <= u8sd_pkg::SurrogateHi) ok = 1'b0;
        if (partial > u8sd_pkg::MaxScalar) ok = 1'b0;
        if (ok) begin
          emit(partial, {1'b0, need} + 3'd1);
          clear();
        end else begin
          flush();
        end
      end else if (eob) begin
        flush();
      end
    end else begin
      flush();
      take_fresh(b, eob);
    end
    if (byte_results.size() > 0) begin
      r = byte_results.pop_back();
      r.run_last = 1'b1;
      byte_results.push_back(r);
    end
    foreach (byte_results[i]) code_points_due.push_back(byte_results[i]);
  endfunction

  function void check_result(u8sd_pkg::out_req_t got);
    u8sd_pkg::out_req_t want;
    if (code_points_due.size() == 0) begin
      $error("unexpected request: code_point %h seq_length %0d run_last %0d",
             got.code_point, got.seq_length, got.run_last);
      errors++;
      return;
    end
    want = code_points_due.pop_front();
    if (got.code_point !== want.code_point) begin
      $error("code_point: expected %h, actual %h", want.code_point, got.code_point);
      errors++;
    end
    if (got.seq_length !== want.seq_length) begin
      $error("seq_length: expected %0d, actual %0d", want.seq_length, got.seq_length);
      errors++;
    end
    if (got.run_last !== want.run_last) begin
      $error("run_last: expected %0d, actual %0d", want.run_last, got.run_last);
      errors++;
    end
  endfunction

  function int pending();
    return code_points_due.size();
  endfunction
endclass

module utf8_stream_decoder_test;
  import u8sd_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 20;
  localparam int PhaseBytes  = 140;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_req_t out_req_o;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent    = 0;
  int cycle_count   = 0;

  utf8_scoreboard decoded_check;

  utf8_stream_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= (int'($urandom_range(99)) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) decoded_check.note_byte(in_req_i);
      if (out_valid_o && !out_stall_i) decoded_check.check_result(out_req_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("utf8_stream_decoder_test: FAIL");
      $finish;
    end
  end

  function automatic logic pick_eob();
    return ($urandom_range(15) == 0);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eob);
    in_req_t r;
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    r.in_byte       = b;
    r.end_of_buffer = eob;
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // well-formed, random-content or truncated sequences, and loose bytes
  task automatic send_sequence();
    int          sel;
    int          n;
    int          keep;
    logic [20:0] cp;
    logic [7:0]  b [4];
    sel = int'($urandom_range(99));
    if (sel >= 85) begin
      send_byte(8'($urandom_range(255)), pick_eob());
      return;
    end
    n = int'($urandom_range(4, 1));
    if (sel < 55) begin
      case (n)
        1:       cp = 21'($urandom_range(32'h7F));
        2:       cp = 21'($urandom_range(32'h7FF, 32'h80));
        3:       cp = 21'($urandom_range(32'hFFFF, 32'h800));
        default: cp = 21'($urandom_range(32'h10FFFF, 32'h10000));
      endcase
    end else begin
      cp = 21'($urandom_range(32'h1FFFFF));
    end
    case (n)
      1: b[0] = {1'b0, cp[6:0]};
      2: begin
        b[0] = {3'b110, cp[10:6]};
        b[1] = {2'b10, cp[5:0]};
      end
      3: begin
        b[0] = {4'b1110, cp[15:12]};
        b[1] = {2'b10, cp[11:6]};
        b[2] = {2'b10, cp[5:0]};
      end
      default: begin
        b[0] = {5'b11110, cp[20:18]};
        b[1] = {2'b10, cp[17:12]};
        b[2] = {2'b10, cp[11:6]};
        b[3] = {2'b10, cp[5:0]};
      end
    endcase
    keep = n;
    if (sel >= 70 && n > 1) keep = int'($urandom_range(n - 1, 1));
    for (int i = 0; i < keep; i++) send_byte(b[i], pick_eob());
  endtask

  initial begin
    decoded_check = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 10;
    recv_idle_pct = 50;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    // overlong, then a valid three-byte sequence
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    // surrogate
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    // above 10FFFF, then exactly 10FFFF
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // breaking byte
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'h41, 1'b0);
    // early end, then lead as final byte
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'hC3, 1'b1);

    while (bytes_sent < PhaseBytes) send_sequence();
    send_idle_pct = 50;
    recv_idle_pct = 10;
    while (bytes_sent < 2 * PhaseBytes) send_sequence();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (bytes_sent < 3 * PhaseBytes) send_sequence();
    in_valid_i <= 1'b0;

    while (decoded_check.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (decoded_check.errors == 0) begin
      $display("utf8_stream_decoder_test: PASS");
    end else begin
      $display("utf8_stream_decoder_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: utf8_stream_decoder.f
hdl/u8sd_pkg.sv
hdl/u8sd_front.sv
hdl/u8sd_queue.sv
hdl/u8sd_back.sv
hdl/utf8_stream_decoder.sv
dv/utf8_stream_decoder_test.sv
